### src/shift_add_multiply_restoring_divide_alu_core_defines.svh
// assertion macros used by the alu core controller
`ifndef SHIFT_ADD_MULTIPLY_RESTORING_DIVIDE_ALU_CORE_DEFINES_SVH
`define SHIFT_ADD_MULTIPLY_RESTORING_DIVIDE_ALU_CORE_DEFINES_SVH

// checked on every rising edge outside reset
`define SARD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define SARD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### src/sardalu_pkg.sv
// package: operand width, function codes, beat types and controller types
`timescale 1ns / 1ps

package sardalu_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int CNT_W         = (OPERAND_WIDTH > 2) ? $clog2(OPERAND_WIDTH) : 1;

    typedef enum logic [2:0] {
        FN_ADD      = 3'd0,
        FN_SUB      = 3'd1,
        FN_MUL_LO   = 3'd2,
        FN_DIV      = 3'd3,
        FN_REM      = 3'd4,
        FN_MUL_WIDE = 3'd5
    } t_func;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] operand_a;
        logic [31:0] operand_b;
    } t_req;

    typedef struct packed {
        logic [31:0] result_low;
        logic [31:0] result_high;
        logic        divide_by_zero;
        logic        a_less_than_b;
        logic        a_equals_b;
    } t_resp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic iterate;
    } t_dp_status;

endpackage

### src/sardalu_dp.sv
// datapath: operand registers, shared shift register pair, result register
`timescale 1ns / 1ps

module sardalu_dp (
    input  logic                   i_clk,
    input  sardalu_pkg::t_req      i_req,
    input  sardalu_pkg::t_dp_cmd   i_cmd,
    output sardalu_pkg::t_dp_status o_status,
    output sardalu_pkg::t_resp     o_resp
);

    localparam int W = sardalu_pkg::OPERAND_WIDTH;

    logic [2:0]   r_func;
    logic [W-1:0] r_a, r_b, r_hi, r_lo;
    logic [W-1:0] n_hi, n_lo;
    sardalu_pkg::t_resp r_resp, n_resp;

    logic [W-1:0] in_a, in_b;
    logic         in_mul, in_div;
    logic         run_mul;
    logic [W:0]   mul_sum;
    logic [W:0]   rem_sh;
    logic [W+1:0] rem_diff;
    logic         rem_ge;

    assign in_a   = i_req.operand_a[W-1:0];
    assign in_b   = i_req.operand_b[W-1:0];
    assign in_mul = (i_req.func == sardalu_pkg::FN_MUL_LO) ||
                    (i_req.func == sardalu_pkg::FN_MUL_WIDE);
    assign in_div = (i_req.func == sardalu_pkg::FN_DIV) ||
                    (i_req.func == sardalu_pkg::FN_REM);

    assign o_status.iterate = in_mul || (in_div && (in_b != '0));

    assign run_mul = (r_func == sardalu_pkg::FN_MUL_LO) ||
                     (r_func == sardalu_pkg::FN_MUL_WIDE);

    // multiply: hi accumulates, lo holds the multiplier and catches product bits
    assign mul_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);

    // divide: lo holds the dividend and collects quotient bits
    assign rem_sh   = {r_hi, r_lo[W-1]};
    assign rem_diff = {1'b0, rem_sh} - {2'b00, r_b};
    assign rem_ge   = !rem_diff[W+1];

    always_comb begin
        if (run_mul) begin
            n_hi = mul_sum[W:1];
            n_lo = {mul_sum[0], r_lo[W-1:1]};
        end else begin
            n_hi = rem_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
            n_lo = {r_lo[W-2:0], rem_ge};
        end
    end

    always_comb begin
        n_resp                = '0;
        n_resp.a_less_than_b  = (r_a < r_b);
        n_resp.a_equals_b     = (r_a == r_b);
        case (r_func)
            sardalu_pkg::FN_ADD: begin
                n_resp.result_low = 32'(r_a + r_b);
            end
            sardalu_pkg::FN_SUB: begin
                n_resp.result_low = 32'(r_a - r_b);
            end
            sardalu_pkg::FN_MUL_LO: begin
                n_resp.result_low = 32'(r_lo);
            end
            sardalu_pkg::FN_MUL_WIDE: begin
                n_resp.result_low  = 32'(r_lo);
                n_resp.result_high = 32'(r_hi);
            end
            sardalu_pkg::FN_DIV: begin
                if (r_b == '0) begin
                    n_resp.divide_by_zero = 1'b1;
                end else begin
                    n_resp.result_low  = 32'(r_lo);
                    n_resp.result_high = 32'(r_hi);
                end
            end
            sardalu_pkg::FN_REM: begin
                if (r_b == '0) begin
                    n_resp.divide_by_zero = 1'b1;
                end else begin
                    n_resp.result_low = 32'(r_hi);
                end
            end
            default: begin
                n_resp.result_low = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_req.func;
            r_a    <= in_a;
            r_b    <= in_b;
            r_hi   <= '0;
            r_lo   <= in_mul ? in_b : in_a;
        end else if (i_cmd.step) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
        if (i_cmd.finish) begin
            r_resp <= n_resp;
        end
    end

    assign o_resp = r_resp;

endmodule

### src/sardalu_ctrl.sv
// controller: sequencer state, step counter and output valid
`timescale 1ns / 1ps
`include "shift_add_multiply_restoring_divide_alu_core_defines.svh"

module sardalu_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  sardalu_pkg::t_dp_status i_status,
    output sardalu_pkg::t_dp_cmd    o_cmd
);

    localparam int CW = sardalu_pkg::CNT_W;
    localparam logic [CW-1:0] CNT_LAST = CW'(sardalu_pkg::OPERAND_WIDTH - 1);

    sardalu_pkg::t_state r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_out_valid, n_out_valid;
    logic                in_beat, slot_free;

    assign slot_free = !r_out_valid || i_out_ready;
    assign in_beat   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sardalu_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            sardalu_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = i_status.iterate ? sardalu_pkg::S_RUN : sardalu_pkg::S_FIN;
                end
            end
            sardalu_pkg::S_RUN: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = sardalu_pkg::S_FIN;
                end
            end
            sardalu_pkg::S_FIN: begin
                // wait until the output register is free or being drained
                if (slot_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = sardalu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sardalu_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

    `SARD_ASSERT(a_run_ends, (r_state == sardalu_pkg::S_RUN && r_cnt == CNT_LAST) |=> (r_state == sardalu_pkg::S_FIN), "iteration did not end after last step")
    `SARD_ASSERT(a_no_overwrite, o_cmd.finish |-> (!r_out_valid || i_out_ready), "result register overwritten while held")
    `SARD_ASSERT(a_busy_after_beat, in_beat |=> !o_in_ready, "accepted a second beat before finishing")
    `SARD_ASSERT_ALWAYS(a_one_cmd, $onehot0(o_cmd), "more than one datapath command at once")

endmodule

### src/shift_add_multiply_restoring_divide_alu_core.sv
// Integer ALU core: add, subtract, shift-add multiply and restoring divide.
// Input channel i_in_valid / o_in_ready carries func, operand_a, operand_b;
// output channel o_out_valid / i_out_ready carries the low and high result
// words, the divide-by-zero flag and the a<b / a==b compare flags.
// Only the low OPERAND_WIDTH bits of each operand are used.
// One item is worked on at a time. Add, subtract, unused codes and divide by
// zero go from the input beat straight to the finish state. Multiply and
// divide/remainder run one bit per cycle through a shared hi/lo shift
// register pair and then pass to the finish state, which loads the output
// register and raises output valid.
// The finished result sits in an output register, so the next input beat
// is taken while an earlier result still waits for the receiver. If the
// receiver stalls with a result held, a second finished result waits in the
// datapath until the output register drains, and no new beat is taken.
// Synchronous active-low reset returns the sequencer to idle and drops
// o_out_valid; there is no clearing pass.
`timescale 1ns / 1ps

module shift_add_multiply_restoring_divide_alu_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sardalu_pkg::t_req  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sardalu_pkg::t_resp o_out_data
);

    sardalu_pkg::t_dp_cmd    dp_cmd;
    sardalu_pkg::t_dp_status dp_status;

    sardalu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    sardalu_dp u_dp (
        .i_clk    (i_clk),
        .i_req    (i_in_data),
        .i_cmd    (dp_cmd),
        .o_status (dp_status),
        .o_resp   (o_out_data)
    );

endmodule

### tb/shift_add_multiply_restoring_divide_alu_core_tb.sv
`timescale 1ns / 1ps
// alu core testbench: typed and predicted directed rows, then predicted random beats
module shift_add_multiply_restoring_divide_alu_core_tb;
    import sardalu_pkg::*;

    localparam int          CLK_HALF     = 10;
    localparam int          RESET_CYCLES = 7;
    localparam int          RANDOM_BEATS = 1950;
    localparam int          QUIET_BEATS  = 150;
    localparam int          HOLD_AT      = 300;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 40;
    localparam logic [2:0]  FN_UNUSED_6  = 3'd6;
    localparam logic [2:0]  FN_UNUSED_7  = 3'd7;
    localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
    localparam logic [31:0] TOP_BIT      = 32'h8000_0000;

    typedef struct {
        t_req  req;
        bit    typed;
        t_resp resp;
    } t_vector;

    logic    clk         = 1'b0;
    logic    rst_n       = 1'b0;
    logic    in_valid    = 1'b0;
    logic    in_ready;
    t_req    in_data     = '0;
    logic    out_valid;
    logic    out_ready   = 1'b0;
    t_resp   out_data;
    t_resp   next_expect = '0;
    logic    tail_quiet  = 1'b0;
    int      ops_issued  = 0;
    int      results_seen = 0;
    int      fail_count  = 0;
    t_resp   alu_results_due [$];
    t_vector directed [$];

    shift_add_multiply_restoring_divide_alu_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial begin
        #(15_000_000);
        $display("FAIL");
        $finish;
    end

    function automatic t_resp alu_outcome(input t_req r);
        logic [63:0] mask;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] prod;
        t_resp       o;
        mask = (64'd1 << OPERAND_WIDTH) - 64'd1;
        a    = {32'd0, r.operand_a} & mask;
        b    = {32'd0, r.operand_b} & mask;
        prod = a * b;
        o    = '0;
        case (r.func)
            FN_ADD:      o.result_low = 32'((a + b) & mask);
            FN_SUB:      o.result_low = 32'((a - b) & mask);
            FN_MUL_LO:   o.result_low = 32'(prod & mask);
            FN_MUL_WIDE: begin
                o.result_low  = 32'(prod & mask);
                o.result_high = 32'((prod >> OPERAND_WIDTH) & mask);
            end
            FN_DIV, FN_REM: begin
                if (b == 64'd0) begin
                    o.divide_by_zero = 1'b1;
                end else if (r.func == FN_DIV) begin
                    o.result_low  = 32'(a / b);
                    o.result_high = 32'(a % b);
                end else begin
                    o.result_low = 32'(a % b);
                end
            end
            default: ;
        endcase
        o.a_less_than_b = (a < b);
        o.a_equals_b    = (a == b);
        return o;
    endfunction

    function automatic t_vector typed_row(input logic [2:0] f, input logic [31:0] a,
                                          input logic [31:0] b, input logic [31:0] lo,
                                          input logic [31:0] hi, input logic dz,
                                          input logic lt, input logic eq);
        t_vector v;
        v.req   = '{f, a, b};
        v.typed = 1'b1;
        v.resp  = '{lo, hi, dz, lt, eq};
        return v;
    endfunction

    function automatic t_vector predicted_row(input logic [2:0] f, input logic [31:0] a,
                                              input logic [31:0] b);
        t_vector v;
        v.req   = '{f, a, b};
        v.typed = 1'b0;
        v.resp  = '0;
        return v;
    endfunction

    function automatic logic [2:0] pick_func();
        case ($urandom_range(0, 19))
            0, 1, 2:    return FN_ADD;
            3, 4, 5:    return FN_SUB;
            6, 7, 8:    return FN_MUL_LO;
            9, 10, 11:  return FN_DIV;
            12, 13, 14: return FN_REM;
            15, 16, 17: return FN_MUL_WIDE;
            18:         return FN_UNUSED_6;
            default:    return FN_UNUSED_7;
        endcase
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return ALL_ONES;
            2:       return 32'($urandom_range(0, 15));
            3:       return 32'd1 << $urandom_range(0, 31);
            4:       return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // one beat: optional gap, then hold valid until taken
    task automatic send_op(input t_req req, input t_resp want, input bit may_idle);
        if (may_idle && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_data     <= req;
        next_expect <= want;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // output side checked before input side so a same-edge beat cannot match itself
    always @(posedge clk) begin : result_check
        t_resp want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                results_seen <= results_seen + 1;
                if (alu_results_due.size() == 0) begin
                    $error("result beat with nothing expected: %h", out_data);
                    fail_count++;
                end else begin
                    want = alu_results_due.pop_front();
                    check_field("result_low", want.result_low, out_data.result_low);
                    check_field("result_high", want.result_high, out_data.result_high);
                    check_field("divide_by_zero", 32'(want.divide_by_zero),
                                32'(out_data.divide_by_zero));
                    check_field("a_less_than_b", 32'(want.a_less_than_b),
                                32'(out_data.a_less_than_b));
                    check_field("a_equals_b", 32'(want.a_equals_b),
                                32'(out_data.a_equals_b));
                end
            end
            if (in_valid && in_ready) begin
                alu_results_due.push_back(next_expect);
                ops_issued <= ops_issued + 1;
            end
        end
    end

    initial begin : result_sink
        int c;
        bit hold_done;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!hold_done && ops_issued >= HOLD_AT) begin
                // long back-pressure so the core fills and stops taking beats
                hold_done = 1'b1;
                out_ready <= 1'b0;
                for (c = 0; c < HOLD_CYCLES; c++) @(posedge clk);
            end else if (!tail_quiet && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    initial begin : stimulus
        t_req  req;
        t_resp want;
        int    n;

        directed.push_back(typed_row(FN_ADD, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 1'b1));
        directed.push_back(typed_row(FN_ADD, ALL_ONES, 32'd1, 32'd0, 32'd0, 1'b0, 1'b0, 1'b0));
        directed.push_back(typed_row(FN_SUB, 32'd0, 32'd1, ALL_ONES, 32'd0, 1'b0, 1'b1, 1'b0));
        directed.push_back(typed_row(FN_MUL_LO, ALL_ONES, ALL_ONES, 32'd1, 32'd0,
                                     1'b0, 1'b0, 1'b1));
        directed.push_back(typed_row(FN_MUL_WIDE, ALL_ONES, ALL_ONES, 32'd1, 32'hFFFF_FFFE,
                                     1'b0, 1'b0, 1'b1));
        directed.push_back(typed_row(FN_MUL_WIDE, 32'd0, ALL_ONES, 32'd0, 32'd0,
                                     1'b0, 1'b1, 1'b0));
        // zero divisor
        directed.push_back(typed_row(FN_DIV, 32'd5, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0));
        directed.push_back(typed_row(FN_REM, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b1));
        directed.push_back(typed_row(FN_REM, ALL_ONES, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 1'b0));
        directed.push_back(typed_row(FN_DIV, ALL_ONES, 32'd1, ALL_ONES, 32'd0,
                                     1'b0, 1'b0, 1'b0));
        directed.push_back(typed_row(FN_DIV, 32'd1, ALL_ONES, 32'd0, 32'd1, 1'b0, 1'b1, 1'b0));
        // unused codes still give the compare flags
        directed.push_back(typed_row(FN_UNUSED_6, 32'd3, 32'd9, 32'd0, 32'd0,
                                     1'b0, 1'b1, 1'b0));
        directed.push_back(typed_row(FN_UNUSED_7, ALL_ONES, ALL_ONES, 32'd0, 32'd0,
                                     1'b0, 1'b0, 1'b1));
        directed.push_back(predicted_row(FN_ADD, 32'h1234_5678, 32'h9ABC_DEF0));
        directed.push_back(predicted_row(FN_ADD, TOP_BIT, TOP_BIT));
        directed.push_back(predicted_row(FN_SUB, 32'h7FFF_FFFF, TOP_BIT));
        directed.push_back(predicted_row(FN_SUB, ALL_ONES, ALL_ONES));
        directed.push_back(predicted_row(FN_MUL_LO, TOP_BIT, 32'd2));
        directed.push_back(predicted_row(FN_MUL_WIDE, 32'hDEAD_BEEF, 32'h1234_5678));
        directed.push_back(predicted_row(FN_MUL_WIDE, TOP_BIT, TOP_BIT));
        directed.push_back(predicted_row(FN_DIV, ALL_ONES, 32'h0001_0000));
        directed.push_back(predicted_row(FN_DIV, 32'd100, 32'd7));
        directed.push_back(predicted_row(FN_DIV, 32'h0000_1234, 32'hFFFF_0000));
        directed.push_back(predicted_row(FN_REM, TOP_BIT, 32'd3));
        directed.push_back(predicted_row(FN_REM, 32'hCAFE_F00D, 32'hCAFE_F00D));

        @(posedge clk);
        while (!rst_n) @(posedge clk);

        foreach (directed[k]) begin
            want = directed[k].typed ? directed[k].resp : alu_outcome(directed[k].req);
            send_op(directed[k].req, want, 1'b1);
        end

        // let everything drain before the random part
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_seen != ops_issued) @(posedge clk);

        for (n = 0; n < RANDOM_BEATS; n++) begin
            if (n == RANDOM_BEATS - QUIET_BEATS) tail_quiet <= 1'b1;
            req.func      = pick_func();
            req.operand_a = pick_operand();
            req.operand_b = pick_operand();
            if ($urandom_range(0, 15) == 0) req.operand_b = req.operand_a;
            send_op(req, alu_outcome(req), n < RANDOM_BEATS - QUIET_BEATS);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (results_seen != ops_issued) @(posedge clk);
        // catch any stray result beat
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && alu_results_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/sardalu_pkg.sv
src/sardalu_dp.sv
src/sardalu_ctrl.sv
src/shift_add_multiply_restoring_divide_alu_core.sv
tb/shift_add_multiply_restoring_divide_alu_core_tb.sv
